### hdl/prq_pkg.sv
// prq_pkg: shared widths, command and error codes, default sizes
// for the priority bucket ready queue; depends on nothing
package prq_pkg;

   localparam int TASK_W = 4;
   localparam int CMD_W  = 2;
   localparam int PRIO_W = 8;
   localparam int ERR_W  = 2;

   localparam int DEF_TASK_COUNT = 16;
   localparam int DEF_NUM_LEVELS = 256;

   // levels per group of the two-step level search
   localparam int GRP_W = 16;

   localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

   localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
   localparam logic [ERR_W-1:0] ERR_DUPLICATE  = 2'd1;
   localparam logic [ERR_W-1:0] ERR_NOT_QUEUED = 2'd2;

endpackage

### hdl/prq_ram.sv
// prq_ram: generic simple dual-port ram, one write and one registered read
// port; depends on nothing
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/priority_bucket_ready_queue.sv
// priority_bucket_ready_queue: ready queue with per-level fifo lists
// depends on prq_pkg and prq_ram (level head/tail ram, task link ram)
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/stall    command, task_id, priority_req
//   rsp_        out        rsp_valid/stall    next_task, all_empty, error
//
// one transaction at a time: each command passes decode, the two-step level
// search and the head read; enqueue to a filled level and remove add ram
// steps, remove of a middle task the most; the link ram has one read port.
// reset clears the valid bits at once, no clearing pass. a stalled result sits
// in the output register; the next request is taken meanwhile and its result
// waits in the done state.
module priority_bucket_ready_queue #(
   parameter int TASK_COUNT = prq_pkg::DEF_TASK_COUNT,
   parameter int NUM_LEVELS = prq_pkg::DEF_NUM_LEVELS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [prq_pkg::CMD_W-1:0]  req_command,
   input  logic [prq_pkg::TASK_W-1:0] req_task_id,
   input  logic [prq_pkg::PRIO_W-1:0] req_priority_req,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [prq_pkg::TASK_W-1:0] rsp_next_task,
   output logic                       rsp_all_empty,
   output logic [prq_pkg::ERR_W-1:0]  rsp_error
);

   localparam int TW     = prq_pkg::TASK_W;
   localparam int TIDX_W = $clog2(TASK_COUNT);
   localparam int LVL_W  = $clog2(NUM_LEVELS);
   localparam int GW     = prq_pkg::GRP_W;
   localparam int GB_W   = $clog2(GW);
   localparam int NG     = (NUM_LEVELS + GW - 1) / GW;
   localparam int GIDX_W = (NG > 1) ? $clog2(NG) : 1;
   localparam int LM_W   = 2 * TW;
   localparam int TM_W   = 2 * TW + LVL_W;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b000000000001,
      S_DEC      = 12'b000000000010,
      S_ENQ_RD   = 12'b000000000100,
      S_ENQ_WR   = 12'b000000001000,
      S_REM_RD1  = 12'b000000010000,
      S_REM_RD2  = 12'b000000100000,
      S_REM_P    = 12'b000001000000,
      S_REM_N    = 12'b000010000000,
      S_FIND_GRP = 12'b000100000000,
      S_FIND_LVL = 12'b001000000000,
      S_HEAD     = 12'b010000000000,
      S_DONE     = 12'b100000000000
   } state_type;

   function automatic logic [TIDX_W-1:0] to_idx(input logic [TW-1:0] id);
      logic [TIDX_W+TW-1:0] e;
      e = {{TIDX_W{1'b0}}, id};
      return e[TIDX_W-1:0];
   endfunction

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [TASK_COUNT-1:0] queued_ff, queued_in;
   logic [NUM_LEVELS-1:0] nonempty_ff, nonempty_in;

   logic [prq_pkg::CMD_W-1:0] cmd_ff;
   logic [TW-1:0]             task_ff;
   logic [TIDX_W-1:0]         tidx_ff;
   logic                      tval_ff;
   logic [LVL_W-1:0]          lvl_ff;
   logic [prq_pkg::ERR_W-1:0] err_ff, err_in;
   logic [TW-1:0]             p_ff, p_in, n_ff, n_in, otail_ff, otail_in;
   logic [LVL_W-1:0]          rlvl_ff, rlvl_in;
   logic [GIDX_W-1:0]         grp_ff, grp_in;
   logic                      any_ff, any_in;
   logic [TW-1:0]             res_task_ff, res_task_in;
   logic                      res_empty_ff, res_empty_in;
   logic [TW-1:0]             rsp_task_ff, rsp_task_in;
   logic                      rsp_empty_ff, rsp_empty_in;
   logic [prq_pkg::ERR_W-1:0] rsp_err_ff, rsp_err_in;

   logic                      lm_we, tm_we;
   logic [LVL_W-1:0]          lm_waddr, lm_raddr;
   logic [LM_W-1:0]           lm_wdata, lm_rdata;
   logic [TIDX_W-1:0]         tm_waddr, tm_raddr;
   logic [TM_W-1:0]           tm_wdata, tm_rdata;

   logic                      accept;
   logic [TIDX_W+TW-1:0]      req_ext;
   logic                      req_tval;
   logic [LVL_W-1:0]          req_lvl;
   logic [NG*GW:0]            ne_ext;
   logic [NG*GW-1:0]          ne_pad;
   logic [NG-1:0]             grp_any;
   logic [GW-1:0]             grp_bits;
   logic [GB_W-1:0]           bit_sel;
   logic [GIDX_W+GB_W-1:0]    found_full;

   logic [TW-1:0]    lm_head, lm_tail, tm_next, tm_prev;
   logic [LVL_W-1:0] tm_level;

   assign lm_head  = lm_rdata[LM_W-1:TW];
   assign lm_tail  = lm_rdata[TW-1:0];
   assign tm_next  = tm_rdata[TM_W-1:TW+LVL_W];
   assign tm_prev  = tm_rdata[TW+LVL_W-1:LVL_W];
   assign tm_level = tm_rdata[LVL_W-1:0];

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign req_ext   = {{TIDX_W{1'b0}}, req_task_id};
   assign req_tval  = (req_ext < (TIDX_W+TW)'(TASK_COUNT));

   always_comb begin
      if ({1'b0, req_priority_req} >= (prq_pkg::PRIO_W+1)'(NUM_LEVELS)) begin
         req_lvl = LVL_W'(NUM_LEVELS - 1);
      end else begin
         req_lvl = req_priority_req[LVL_W-1:0];
      end
   end

   // level search, group summary then bit within the group
   assign ne_ext = {{(NG*GW-NUM_LEVELS+1){1'b0}}, nonempty_ff};
   assign ne_pad = ne_ext[NG*GW-1:0];

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_any[g] = |ne_pad[g*GW +: GW];
      end
      grp_in = grp_ff;
      any_in = any_ff;
      if (state_ff == S_FIND_GRP) begin
         grp_in = '0;
         any_in = |grp_any;
         for (int g = NG - 1; g >= 0; g--) begin
            if (grp_any[g]) begin
               grp_in = GIDX_W'(g);
            end
         end
      end
      grp_bits = ne_pad[int'(grp_ff)*GW +: GW];
      bit_sel  = '0;
      for (int b = GW - 1; b >= 0; b--) begin
         if (grp_bits[b]) begin
            bit_sel = GB_W'(b);
         end
      end
      found_full = {grp_ff, bit_sel};
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      queued_in    = queued_ff;
      nonempty_in  = nonempty_ff;
      err_in       = err_ff;
      p_in         = p_ff;
      n_in         = n_ff;
      otail_in     = otail_ff;
      rlvl_in      = rlvl_ff;
      res_task_in  = res_task_ff;
      res_empty_in = res_empty_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_err_in   = rsp_err_ff;
      lm_we    = 1'b0;
      lm_waddr = lvl_ff;
      lm_wdata = '0;
      lm_raddr = lvl_ff;
      tm_we    = 1'b0;
      tm_waddr = tidx_ff;
      tm_wdata = '0;
      tm_raddr = tidx_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            err_in   = prq_pkg::ERR_NONE;
            state_in = S_FIND_GRP;
            unique case (cmd_ff)
               prq_pkg::CMD_ENQUEUE: begin
                  if (tval_ff && queued_ff[tidx_ff]) begin
                     err_in = prq_pkg::ERR_DUPLICATE;
                  end else if (tval_ff && nonempty_ff[lvl_ff]) begin
                     lm_raddr = lvl_ff;
                     state_in = S_ENQ_RD;
                  end else if (tval_ff) begin
                     lm_we    = 1'b1;
                     lm_waddr = lvl_ff;
                     lm_wdata = {task_ff, task_ff};
                     tm_we    = 1'b1;
                     tm_waddr = tidx_ff;
                     tm_wdata = {{TW{1'b0}}, {TW{1'b0}}, lvl_ff};
                     nonempty_in[lvl_ff] = 1'b1;
                     queued_in[tidx_ff]  = 1'b1;
                  end
               end
               prq_pkg::CMD_REMOVE: begin
                  if (tval_ff && queued_ff[tidx_ff]) begin
                     tm_raddr = tidx_ff;
                     state_in = S_REM_RD1;
                  end else begin
                     err_in = prq_pkg::ERR_NOT_QUEUED;
                  end
               end
               default: begin
               end
            endcase
         end
         S_ENQ_RD: begin
            otail_in = lm_tail;
            lm_we    = 1'b1;
            lm_waddr = lvl_ff;
            lm_wdata = {lm_head, task_ff};
            tm_raddr = to_idx(lm_tail);
            tm_we    = 1'b1;
            tm_waddr = tidx_ff;
            tm_wdata = {{TW{1'b0}}, lm_tail, lvl_ff};
            state_in = S_ENQ_WR;
         end
         S_ENQ_WR: begin
            tm_we    = 1'b1;
            tm_waddr = to_idx(otail_ff);
            tm_wdata = {task_ff, tm_prev, tm_level};
            queued_in[tidx_ff] = 1'b1;
            state_in = S_FIND_GRP;
         end
         S_REM_RD1: begin
            p_in     = tm_prev;
            n_in     = tm_next;
            rlvl_in  = tm_level;
            lm_raddr = tm_level;
            state_in = S_REM_RD2;
         end
         S_REM_RD2: begin
            queued_in[tidx_ff] = 1'b0;
            lm_waddr = rlvl_ff;
            state_in = S_FIND_GRP;
            priority if (lm_head == task_ff && lm_tail == task_ff) begin
               nonempty_in[rlvl_ff] = 1'b0;
            end else if (lm_head == task_ff) begin
               lm_we    = 1'b1;
               lm_wdata = {n_ff, lm_tail};
            end else if (lm_tail == task_ff) begin
               lm_we    = 1'b1;
               lm_wdata = {lm_head, p_ff};
            end else begin
               tm_raddr = to_idx(p_ff);
               state_in = S_REM_P;
            end
         end
         S_REM_P: begin
            tm_we    = 1'b1;
            tm_waddr = to_idx(p_ff);
            tm_wdata = {n_ff, tm_prev, tm_level};
            tm_raddr = to_idx(n_ff);
            state_in = S_REM_N;
         end
         S_REM_N: begin
            tm_we    = 1'b1;
            tm_waddr = to_idx(n_ff);
            tm_wdata = {tm_next, p_ff, tm_level};
            state_in = S_FIND_GRP;
         end
         S_FIND_GRP: begin
            state_in = S_FIND_LVL;
         end
         S_FIND_LVL: begin
            lm_raddr = found_full[LVL_W-1:0];
            state_in = S_HEAD;
         end
         S_HEAD: begin
            res_task_in  = any_ff ? lm_head : '0;
            res_empty_in = !any_ff;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_task_in  = res_task_ff;
               rsp_empty_in = res_empty_ff;
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         queued_ff    <= '0;
         nonempty_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         queued_ff    <= queued_in;
         nonempty_ff  <= nonempty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_command;
         task_ff <= req_task_id;
         tidx_ff <= req_ext[TIDX_W-1:0];
         tval_ff <= req_tval;
         lvl_ff  <= req_lvl;
      end
      err_ff       <= err_in;
      p_ff         <= p_in;
      n_ff         <= n_in;
      otail_ff     <= otail_in;
      rlvl_ff      <= rlvl_in;
      grp_ff       <= grp_in;
      any_ff       <= any_in;
      res_task_ff  <= res_task_in;
      res_empty_ff <= res_empty_in;
      rsp_task_ff  <= rsp_task_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // head and tail per level
   prq_ram #(
      .WIDTH(LM_W),
      .DEPTH(NUM_LEVELS)
   ) u_level_ram (
      .clock  (clock),
      .wr_en  (lm_we),
      .wr_addr(lm_waddr),
      .wr_data(lm_wdata),
      .rd_addr(lm_raddr),
      .rd_data(lm_rdata)
   );

   // next link, prev link and level per task
   prq_ram #(
      .WIDTH(TM_W),
      .DEPTH(TASK_COUNT)
   ) u_task_ram (
      .clock  (clock),
      .wr_en  (tm_we),
      .wr_addr(tm_waddr),
      .wr_data(tm_wdata),
      .rd_addr(tm_raddr),
      .rd_data(tm_rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_next_task = rsp_task_ff;
   assign rsp_all_empty = rsp_empty_ff;
   assign rsp_error     = rsp_err_ff;

endmodule
